// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property at every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/bmprgb_pkg.sv =====
// Shared types and constants of the BMP to RGB565 pixel decoder
package bmprgb_pkg;

   localparam int MaxDimDefault     = 2048;
   localparam int QueueDepthDefault = 2;

   localparam logic [15:0] BmpSignature = 16'h4D42;
   localparam logic [15:0] Bpp24        = 16'd24;
   localparam logic [15:0] Bpp32        = 16'd32;

   // file byte index at which each header field is complete
   localparam logic [31:0] PosSignatureEnd = 32'd1;
   localparam logic [31:0] PosOffsetEnd    = 32'd13;
   localparam logic [31:0] PosWidthEnd     = 32'd21;
   localparam logic [31:0] PosHeightEnd    = 32'd25;
   localparam logic [31:0] PosDepthEnd     = 32'd29;

   localparam logic [10:0] OriginReset         = 11'd0;
   localparam logic [11:0] LcdWidthReset       = 12'd800;
   localparam logic [11:0] LcdHeightReset      = 12'd480;
   localparam logic [7:0]  AlphaThresholdReset = 8'd50;

   localparam logic [2:0] RegOriginX        = 3'd0;
   localparam logic [2:0] RegOriginY        = 3'd1;
   localparam logic [2:0] RegLcdWidth       = 3'd2;
   localparam logic [2:0] RegLcdHeight      = 3'd3;
   localparam logic [2:0] RegAlphaThreshold = 3'd4;

   typedef enum logic [1:0] {
      KIND_DRAW          = 2'd0,
      KIND_BAD_SIGNATURE = 2'd1,
      KIND_BAD_DEPTH     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_ERR_SIGNATURE = 2'd0,
      OP_ERR_DEPTH     = 2'd1,
      OP_PIX_FIRST     = 2'd2,
      OP_PIX           = 2'd3
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      logic [7:0]  data;
      logic [31:0] width;
      logic [31:0] height;
      logic        is32;
   } op_type;

   typedef struct packed {
      logic [10:0] origin_x;
      logic [10:0] origin_y;
      logic [11:0] lcd_width;
      logic [11:0] lcd_height;
      logic [7:0]  alpha_threshold;
   } cfg_type;

endpackage

// ===== rtl/bmprgb_front.sv =====
// Front end: header parse and classification of each file byte into queue ops
`include "assert_macros.svh"

module bmprgb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   input  logic                in_sof,
   output logic                push,
   output bmprgb_pkg::op_type  push_op,
   input  logic                queue_full
);
   import bmprgb_pkg::*;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_PIXELS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [31:0] count_ff, count_in;
   logic [31:0] shift_ff, shift_in, shift_new;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic        is32_ff, is32_in;
   logic [31:0] pos;
   logic        accept;
   logic        restart, in_done;

   assign in_ready  = !queue_full;
   assign accept    = in_valid && !queue_full;
   assign pos       = in_sof ? 32'd0 : count_ff;
   assign phase_cur = in_sof ? PH_HEADER : phase_ff;
   assign shift_new = {in_byte, (in_sof ? 24'd0 : shift_ff[31:8])};
   assign restart   = accept && in_sof;
   assign in_done   = (phase_ff == PH_DONE);

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      shift_in       = shift_ff;
      offset_in      = offset_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      is32_in        = is32_ff;
      push           = 1'b0;
      push_op.code   = OP_PIX;
      push_op.data   = in_byte;
      push_op.width  = width_ff;
      push_op.height = height_ff;
      push_op.is32   = is32_ff;
      if (accept) begin
         phase_in = phase_cur;
         // saturate the byte index at all ones
         count_in = (pos == '1) ? pos : pos + 32'd1;
         case (phase_cur)
            PH_HEADER: begin
               shift_in = shift_new;
               if (pos == PosSignatureEnd) begin
                  if (shift_new[31:16] != BmpSignature) begin
                     phase_in     = PH_DONE;
                     push         = 1'b1;
                     push_op.code = OP_ERR_SIGNATURE;
                  end
               end else if (pos == PosOffsetEnd) begin
                  offset_in = shift_new;
               end else if (pos == PosWidthEnd) begin
                  width_in = shift_new;
               end else if (pos == PosHeightEnd) begin
                  height_in = shift_new;
               end else if (pos == PosDepthEnd) begin
                  is32_in = (shift_new[31:16] == Bpp32);
                  if (shift_new[31:16] != Bpp24 && shift_new[31:16] != Bpp32) begin
                     phase_in     = PH_DONE;
                     push         = 1'b1;
                     push_op.code = OP_ERR_DEPTH;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (pos >= offset_ff) begin
                  phase_in     = PH_PIXELS;
                  push         = 1'b1;
                  push_op.code = OP_PIX_FIRST;
               end
            end
            PH_PIXELS: begin
               push = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= '0;
         shift_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      is32_ff   <= is32_in;
   end

   `ASSERT_CLK(a_done_holds, (in_done && !restart) |=> in_done, "done left without a new file")

endmodule

// ===== rtl/bmprgb_queue.sv =====
// Short op queue between the front end and the pixel back end
`include "assert_macros.svh"

module bmprgb_queue #(
   parameter int Depth = bmprgb_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bmprgb_pkg::op_type  push_op,
   output logic                full,
   input  logic                pop,
   output bmprgb_pkg::op_type  pop_op,
   output logic                not_empty
);
   import bmprgb_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   op_type            mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == CntW'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign pop_op    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   `ASSERT_CLK(a_no_overflow, !(push && full), "op pushed into a full queue")
   `ASSERT_CLK(a_no_underflow, pop |-> not_empty, "op popped from an empty queue")

endmodule

// ===== rtl/bmprgb_back.sv =====
// Back end: row and column tracking, clipping, RGB565 packing and result register
`include "assert_macros.svh"

module bmprgb_back #(
   parameter int MaxDim = bmprgb_pkg::MaxDimDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  bmprgb_pkg::cfg_type cfg,
   input  logic                op_valid,
   input  bmprgb_pkg::op_type  op,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [1:0]          out_kind,
   output logic [10:0]         out_x,
   output logic [10:0]         out_y,
   output logic [15:0]         out_color
);
   import bmprgb_pkg::*;

   localparam int CapMax = (MaxDim < 4095) ? MaxDim : 4095;
   localparam int RowW   = $clog2(CapMax + 1);

   // pixel state
   logic            done_ff, done_in;
   logic [RowW-1:0] rows_ff, rows_in;
   logic [31:0]     idx_ff, idx_in;
   logic [1:0]      within_ff, within_in;
   logic            pad_mode_ff, pad_mode_in;
   logic [1:0]      pad_left_ff, pad_left_in;
   logic [23:0]     pb_ff, pb_in;
   logic [31:0]     w_ff, w_in;
   logic [31:0]     h_ff, h_in;
   logic            is32_ff, is32_in;

   // result register
   logic            out_valid_ff, out_valid_in;
   kind_type        kind_ff, kind_in;
   logic [10:0]     x_ff, x_in;
   logic [10:0]     y_ff, y_in;
   logic [15:0]     color_ff, color_in;

   // values of this beat, with the restart of a new image folded in
   logic            first, take;
   logic [31:0]     w, h, idx;
   logic            is32, done_c, pad_mode;
   logic [RowW-1:0] rows, rows1;
   logic [1:0]      byte_sel, bpb_last;
   logic [11:0]     lw, lh, rows12, rows1_12, y1;
   logic [12:0]     y0_plus_h;
   logic            stop_cols, stop_rows, col_vis, h_ge_lh, row_end;
   logic [23:0]     pb_new;
   logic [15:0]     color;
   logic            is_error, blank_fields;

   assign first    = (op.code == OP_PIX_FIRST);
   assign take     = op_valid && (!out_valid_ff || out_ready);
   assign pop      = take;

   assign w        = first ? op.width  : w_ff;
   assign h        = first ? op.height : h_ff;
   assign is32     = first ? op.is32   : is32_ff;
   assign done_c   = first ? 1'b0 : done_ff;
   assign rows     = first ? '0 : rows_ff;
   assign idx      = first ? 32'd0 : idx_ff;
   assign byte_sel = first ? 2'd0 : within_ff;
   assign pad_mode = first ? 1'b0 : pad_mode_ff;
   assign bpb_last = is32 ? 2'd3 : 2'd2;
   assign rows1    = rows + 1'b1;
   assign rows12   = 12'(rows);
   assign rows1_12 = 12'(rows1);

   assign lw = (cfg.lcd_width  > 12'(CapMax)) ? 12'(CapMax) : cfg.lcd_width;
   assign lh = (cfg.lcd_height > 12'(CapMax)) ? 12'(CapMax) : cfg.lcd_height;

   assign stop_cols = (w == 32'd0) || ({1'b0, cfg.origin_x} >= lw);
   assign stop_rows = ({20'd0, rows12} >= h) ||
                      (({2'b0, cfg.origin_y} + {1'b0, rows12}) >= {1'b0, lh});

   // bottom clip row: either the display edge or the image's own bottom
   assign h_ge_lh   = (h >= {20'd0, lh});
   assign y0_plus_h = {2'b0, cfg.origin_y} + {1'b0, h[11:0]};
   assign y1        = (h_ge_lh || y0_plus_h >= {1'b0, lh}) ? lh : y0_plus_h[11:0];

   assign col_vis = (idx[31:12] == 20'd0) &&
                    (({2'b0, cfg.origin_x} + {1'b0, idx[11:0]}) < {1'b0, lw});

   always_comb begin
      case (byte_sel)
         2'd0:    pb_new = {pb_ff[23:8], op.data};
         2'd1:    pb_new = {pb_ff[23:16], op.data, pb_ff[7:0]};
         2'd2:    pb_new = {op.data, pb_ff[15:0]};
         default: pb_new = pb_ff;
      endcase
   end

   assign color = {pb_new[23:19], pb_new[15:10], pb_new[7:3]};

   always_comb begin
      done_in      = done_ff;
      rows_in      = rows_ff;
      idx_in       = idx_ff;
      within_in    = within_ff;
      pad_mode_in  = pad_mode_ff;
      pad_left_in  = pad_left_ff;
      pb_in        = pb_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      is32_in      = is32_ff;
      out_valid_in = out_valid_ff && !out_ready;
      kind_in      = kind_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      color_in     = color_ff;
      row_end      = 1'b0;
      if (take) begin
         out_valid_in = 1'b0;
         case (op.code)
            OP_ERR_SIGNATURE, OP_ERR_DEPTH: begin
               out_valid_in = 1'b1;
               kind_in      = (op.code == OP_ERR_SIGNATURE) ? KIND_BAD_SIGNATURE
                                                            : KIND_BAD_DEPTH;
               x_in         = '0;
               y_in         = '0;
               color_in     = '0;
            end
            default: begin
               w_in        = w;
               h_in        = h;
               is32_in     = is32;
               done_in     = done_c;
               rows_in     = rows;
               idx_in      = idx;
               within_in   = byte_sel;
               pad_mode_in = pad_mode;
               if (!done_c) begin
                  if (stop_cols || stop_rows) begin
                     done_in = 1'b1;
                  end else if (!pad_mode) begin
                     pb_in = pb_new;
                     if (byte_sel == bpb_last) begin
                        if (col_vis && (!is32 || op.data >= cfg.alpha_threshold)) begin
                           out_valid_in = 1'b1;
                           kind_in      = KIND_DRAW;
                           x_in         = cfg.origin_x + idx[10:0];
                           y_in         = 11'(y1 - 12'd1 - rows12);
                           color_in     = color;
                        end
                        within_in = 2'd0;
                        if (idx + 32'd1 == w) begin
                           idx_in = 32'd0;
                           // 24-bit rows pad 3*width up to a multiple of four
                           if (is32 || w[1:0] == 2'd0) begin
                              row_end = 1'b1;
                           end else begin
                              pad_mode_in = 1'b1;
                              pad_left_in = w[1:0];
                           end
                        end else begin
                           idx_in = idx + 32'd1;
                        end
                     end else begin
                        within_in = byte_sel + 2'd1;
                     end
                  end else begin
                     if (pad_left_ff == 2'd1) begin
                        row_end = 1'b1;
                     end else begin
                        pad_left_in = pad_left_ff - 2'd1;
                     end
                  end
                  if (row_end) begin
                     pad_mode_in = 1'b0;
                     within_in   = 2'd0;
                     idx_in      = 32'd0;
                     rows_in     = rows1;
                     if (({20'd0, rows1_12} >= h) ||
                         (({2'b0, cfg.origin_y} + {1'b0, rows1_12}) >= {1'b0, lh})) begin
                        done_in = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b0;
         rows_ff      <= '0;
         idx_ff       <= '0;
         within_ff    <= '0;
         pad_mode_ff  <= 1'b0;
         pad_left_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rows_ff      <= rows_in;
         idx_ff       <= idx_in;
         within_ff    <= within_in;
         pad_mode_ff  <= pad_mode_in;
         pad_left_ff  <= pad_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pb_ff    <= pb_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      is32_ff  <= is32_in;
      kind_ff  <= kind_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      color_ff <= color_in;
   end

   assign out_valid = out_valid_ff;
   assign out_kind  = kind_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_color = color_ff;

   assign is_error     = out_valid_ff && (kind_ff != KIND_DRAW);
   assign blank_fields = (x_ff == '0) && (y_ff == '0) && (color_ff == '0);

   `ASSERT_CLK(a_error_blank, is_error |-> blank_fields, "error result carries pixel data")

endmodule

// ===== rtl/bmp_stream_to_rgb565_pixels.sv =====
// Top level of the BMP byte stream to RGB565 pixel decoder with its register port
// A byte's result is registered in the queue and then in the result register.
// Throughput: one byte per cycle unless the queue is full; the back end retires one op per cycle.
// The back end stalls only while its result register is full and not taken; the queue holds 2 ops.
// Reset is synchronous: parse state clears, origin 0, display 800 x 480, alpha threshold 50.
// No clearing pass follows reset; the first byte may be accepted right after it.
module bmp_stream_to_rgb565_pixels #(
   parameter int MaxDim     = bmprgb_pkg::MaxDimDefault,
   parameter int QueueDepth = bmprgb_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [10:0] rsp_pixel_x,
   output logic [10:0] rsp_pixel_y,
   output logic [15:0] rsp_color,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bmprgb_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        csr_wr;
   logic [2:0]  csr_index;
   logic        push, pop, queue_full, queue_not_empty;
   op_type      push_op, pop_op;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            RegOriginX:        cfg_in.origin_x        = csr_pwdata[10:0];
            RegOriginY:        cfg_in.origin_y        = csr_pwdata[10:0];
            RegLcdWidth:       cfg_in.lcd_width       = csr_pwdata[11:0];
            RegLcdHeight:      cfg_in.lcd_height      = csr_pwdata[11:0];
            RegAlphaThreshold: cfg_in.alpha_threshold = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         RegOriginX:        csr_prdata = {21'd0, cfg_ff.origin_x};
         RegOriginY:        csr_prdata = {21'd0, cfg_ff.origin_y};
         RegLcdWidth:       csr_prdata = {20'd0, cfg_ff.lcd_width};
         RegLcdHeight:      csr_prdata = {20'd0, cfg_ff.lcd_height};
         RegAlphaThreshold: csr_prdata = {24'd0, cfg_ff.alpha_threshold};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x        <= OriginReset;
         cfg_ff.origin_y        <= OriginReset;
         cfg_ff.lcd_width       <= LcdWidthReset;
         cfg_ff.lcd_height      <= LcdHeightReset;
         cfg_ff.alpha_threshold <= AlphaThresholdReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmprgb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_byte    (req_data_byte),
      .in_sof     (req_start_of_file),
      .push       (push),
      .push_op    (push_op),
      .queue_full (queue_full)
   );

   bmprgb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (queue_full),
      .pop       (pop),
      .pop_op    (pop_op),
      .not_empty (queue_not_empty)
   );

   bmprgb_back #(
      .MaxDim (MaxDim)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_valid  (queue_not_empty),
      .op        (pop_op),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_kind  (rsp_kind),
      .out_x     (rsp_pixel_x),
      .out_y     (rsp_pixel_y),
      .out_color (rsp_color)
   );

endmodule

// ===== dv/bmp_pixel_checker.sv =====
// Checker for the BMP to RGB565 decoder: predicts draw and error beats and compares them
module bmp_pixel_checker #(
   parameter int MaxDim = bmprgb_pkg::MaxDimDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [10:0] rsp_pixel_x,
   input  logic [10:0] rsp_pixel_y,
   input  logic [15:0] rsp_color,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bmprgb_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_SKIP   = 2'd1,
      PH_PIXELS = 2'd2,
      PH_DONE   = 2'd3
   } parse_phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [10:0] x;
      logic [10:0] y;
      logic [15:0] color;
   } pixel_beat_type;

   // display settings as last written through the register port
   logic [10:0] org_x, org_y;
   logic [11:0] lcd_w, lcd_h;
   logic [7:0]  alpha_min;

   // parse state of the current file
   logic [31:0]     byte_index, hdr_window, data_start, img_w, img_h;
   logic [15:0]     depth;
   longint unsigned row_pos;
   int unsigned     rows_finished;
   logic [23:0]     bgr;
   parse_phase_type phase;

   pixel_beat_type beat_q[$];
   int             errors = 0;

   assign fail_count = errors;

   function automatic void restart_file();
      byte_index    = '0;
      hdr_window    = '0;
      data_start    = '0;
      img_w         = '0;
      img_h         = '0;
      depth         = '0;
      row_pos       = 0;
      rows_finished = 0;
      bgr           = '0;
      phase         = PH_HEADER;
   endfunction

   task automatic draw_step(input logic [7:0] b, output logic got, output pixel_beat_type res);
      longint unsigned bpb, w64, data_len, row_len, x0, y0, x1, y1, lw, lh;
      longint unsigned ncols, nrows, byte_sel, idx;
      got = 1'b0;
      res = '0;
      bpb = (depth == Bpp32) ? 64'd4 : 64'd3;
      w64 = 64'(img_w);
      data_len = w64 * bpb;
      row_len = (bpb == 4) ? data_len : ((data_len + 3) & ~64'd3);
      x0 = 64'(org_x);
      y0 = 64'(org_y);
      x1 = x0 + w64;
      y1 = 64'(img_h);
      y1 = y1 + y0;
      lw = (lcd_w > MaxDim) ? 64'(MaxDim) : 64'(lcd_w);
      lh = (lcd_h > MaxDim) ? 64'(MaxDim) : 64'(lcd_h);
      if (x1 > lw) x1 = lw;
      if (y1 > lh) y1 = lh;
      ncols = (x1 > x0) ? x1 - x0 : 64'd0;
      nrows = (y1 > y0) ? y1 - y0 : 64'd0;
      // nothing left to draw: drop the rest of the file
      if (ncols == 0 || nrows == 0 || rows_finished >= nrows || row_len == 0) begin
         phase = PH_DONE;
         return;
      end
      if (row_pos < data_len) begin
         byte_sel = row_pos % bpb;
         idx = row_pos / bpb;
         if (byte_sel < 3) bgr[8*byte_sel +: 8] = b;
         // alpha gates 32-bit pixels only
         if (byte_sel == bpb - 1 && idx < ncols && (bpb == 3 || b >= alpha_min)) begin
            got = 1'b1;
            res.kind = KIND_DRAW;
            res.x = 11'(x0 + idx);
            res.y = 11'(y1 - 1 - rows_finished);
            res.color = {bgr[23:19], bgr[15:10], bgr[7:3]};
         end
      end
      row_pos++;
      if (row_pos >= row_len) begin
         row_pos = 0;
         rows_finished++;
         if (rows_finished >= nrows) phase = PH_DONE;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic sof, output logic got,
                              output pixel_beat_type res);
      logic [31:0] pos;
      got = 1'b0;
      res = '0;
      if (sof) restart_file();
      pos = byte_index;
      if (byte_index != 32'hFFFF_FFFF) byte_index = byte_index + 32'd1;
      case (phase)
         PH_HEADER: begin
            hdr_window = {b, hdr_window[31:8]};
            if (pos == PosSignatureEnd) begin
               if (hdr_window[31:16] != BmpSignature) begin
                  phase = PH_DONE;
                  got = 1'b1;
                  res.kind = KIND_BAD_SIGNATURE;
               end
            end else if (pos == PosOffsetEnd) begin
               data_start = hdr_window;
            end else if (pos == PosWidthEnd) begin
               img_w = hdr_window;
            end else if (pos == PosHeightEnd) begin
               img_h = hdr_window;
            end else if (pos == PosDepthEnd) begin
               depth = hdr_window[31:16];
               if (depth != Bpp24 && depth != Bpp32) begin
                  phase = PH_DONE;
                  got = 1'b1;
                  res.kind = KIND_BAD_DEPTH;
               end else begin
                  phase = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (pos >= data_start) begin
               phase = PH_PIXELS;
               draw_step(b, got, res);
            end
         end
         PH_PIXELS: draw_step(b, got, res);
         default: ;
      endcase
   endtask

   function automatic void check_field(string what, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      logic           got;
      pixel_beat_type res;
      pixel_beat_type want;
      if (reset) begin
         org_x     = OriginReset;
         org_y     = OriginReset;
         lcd_w     = LcdWidthReset;
         lcd_h     = LcdHeightReset;
         alpha_min = AlphaThresholdReset;
         restart_file();
         beat_q.delete();
         pending <= 0;
      end else begin
         // compare first: a byte never yields its beat at the edge it is taken
         if (rsp_valid && rsp_ready) begin
            if (beat_q.size() == 0) begin
               $display("%0t: result mismatch, expected none, got kind %0d x %0d y %0d color %0h",
                        $time, rsp_kind, rsp_pixel_x, rsp_pixel_y, rsp_color);
               errors++;
            end else begin
               want = beat_q.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("pixel_x", 16'(want.x), 16'(rsp_pixel_x));
               check_field("pixel_y", 16'(want.y), 16'(rsp_pixel_y));
               check_field("color", want.color, rsp_color);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               RegOriginX:        org_x = csr_pwdata[10:0];
               RegOriginY:        org_y = csr_pwdata[10:0];
               RegLcdWidth:       lcd_w = csr_pwdata[11:0];
               RegLcdHeight:      lcd_h = csr_pwdata[11:0];
               RegAlphaThreshold: alpha_min = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_start_of_file, got, res);
            if (got) beat_q.push_back(res);
         end
         pending <= beat_q.size();
      end
   end

endmodule

// ===== dv/tb_bmp_stream_to_rgb565_pixels.sv =====
// Testbench top for the BMP to RGB565 decoder: byte stream stimulus, register set-up, verdict
module tb_bmp_stream_to_rgb565_pixels;
   timeunit 1ns;
   timeprecision 1ps;
   import bmprgb_pkg::*;

   localparam int unsigned Items         = 1600;
   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned LongHold      = 300;
   localparam int unsigned DrainCycles   = 4;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte     = '0;
   logic        req_start_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [1:0]  rsp_kind;
   logic [10:0] rsp_pixel_x;
   logic [10:0] rsp_pixel_y;
   logic [15:0] rsp_color;
   logic        csr_psel          = 1'b0;
   logic        csr_penable       = 1'b0;
   logic        csr_pwrite        = 1'b0;
   logic [4:0]  csr_paddr         = '0;
   logic [31:0] csr_pwdata        = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          pending;
   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;
   bit          burst_mode   = 1'b0;
   bit          hold_request = 1'b0;
   logic [7:0]  file_bytes[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bmp_stream_to_rgb565_pixels u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_color         (rsp_color),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   bmp_pixel_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_color         (rsp_color),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   task automatic send_beat(input logic [7:0] d, input logic sof);
      int unsigned gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_start_of_file <= sof;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // hold the byte stream until every pixel beat is out, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int unsigned style);
      logic [31:0] ox, oy, lw, lh, am;
      ox = $urandom_range(0, 15);
      oy = $urandom_range(0, 15);
      lw = 32'(LcdWidthReset);
      lh = 32'(LcdHeightReset);
      am = $urandom_range(0, 255);
      case (style)
         1: begin
            // tight clip window
            ox = $urandom_range(0, 6);
            oy = $urandom_range(0, 6);
            lw = $urandom_range(1, 10);
            lh = $urandom_range(1, 8);
            am = 0;
         end
         2: begin
            // bottom right corner of the largest display
            ox = 2047;
            oy = 2047;
            lw = 2048;
            lh = 2048;
            am = 255;
         end
         3: begin
            lw = 4095;
            lh = 4095;
         end
         4: begin
            // origin may fall outside the display
            ox = $urandom_range(0, 40);
            oy = $urandom_range(0, 40);
            lw = $urandom_range(1, 40);
            lh = $urandom_range(1, 40);
         end
         5: begin
            lw = $urandom_range(0, 1) ? 0 : 4095;
            lh = (lw == 0) ? $urandom_range(0, 4095) : 0;
         end
         default: ;
      endcase
      csr_write(RegOriginX, ox);
      csr_write(RegOriginY, oy);
      csr_write(RegLcdWidth, lw);
      csr_write(RegLcdHeight, lh);
      csr_write(RegAlphaThreshold, am);
   endtask

   function automatic void push_le(logic [31:0] v, int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic int unsigned image_bytes(int unsigned w, int unsigned h, logic [15:0] bpp);
      int unsigned row;
      row = (bpp == Bpp32) ? 4 * w : ((3 * w + 3) / 4) * 4;
      return row * h;
   endfunction

   // build one file and stream it; split_at >= 0 reconfigures before that byte
   task automatic send_file(input logic [15:0] sig, input logic [31:0] offset,
                            input logic [31:0] wid, input logic [31:0] hgt,
                            input logic [15:0] bpp, input int unsigned n_pix,
                            input bit lead_sof, input int split_at);
      file_bytes.delete();
      push_le(32'(sig), 2);
      push_le($urandom, 4);
      push_le($urandom, 4);
      push_le(offset, 4);
      push_le(32'd40, 4);
      push_le(wid, 4);
      push_le(hgt, 4);
      push_le(32'd1, 2);
      push_le(32'(bpp), 2);
      while (file_bytes.size() < offset && file_bytes.size() < 200)
         file_bytes.push_back(8'($urandom));
      repeat (n_pix) file_bytes.push_back(8'($urandom));
      for (int k = 0; k < file_bytes.size(); k++) begin
         if (k == split_at) begin
            settle();
            apply_setting($urandom_range(0, 5));
         end
         send_beat(file_bytes[k], (k == 0) && lead_sof);
      end
   endtask

   task automatic send_random_file();
      int unsigned r, n, off;
      logic [31:0] w, h;
      logic [15:0] bpp, sig;
      r = $urandom_range(0, 99);
      sig = BmpSignature;
      bpp = $urandom_range(0, 1) ? Bpp32 : Bpp24;
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(7, 16);
      case ($urandom_range(0, 3))
         0: off = 0;
         1: off = 30;
         2: off = 54;
         default: off = $urandom_range(26, 60);
      endcase
      n = image_bytes(w, h, bpp);
      if (r < 75) begin
         if ($urandom_range(0, 4) == 0) n += $urandom_range(1, 8);
      end else if (r < 82) begin
         // cut short; the next file restarts the parse
         n = $urandom_range(0, n);
      end else if (r < 88) begin
         sig = 16'($urandom);
         n = $urandom_range(0, 10);
      end else if (r < 94) begin
         bpp = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
         n = $urandom_range(0, 10);
      end else begin
         w = $urandom;
         h = $urandom;
         off = $urandom_range(0, 100);
         n = $urandom_range(0, 20);
      end
      send_file(sig, off, w, h, bpp, n, 1'b1, -1);
   endtask

   initial begin : rsp_side
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LongHold;
         end else begin
            stall = burst_mode ? 0 : $urandom_range(0, 8);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned step;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, first file without a start marker, padded 24-bit rows
      send_file(BmpSignature, 54, 2, 2, Bpp24, image_bytes(2, 2, Bpp24), 1'b0, -1);
      send_file(16'h4D43, 54, 2, 2, Bpp24, 6, 1'b1, -1);
      send_file(BmpSignature, 54, 2, 2, 16'd16, 6, 1'b1, -1);
      // offset below the header end
      send_file(BmpSignature, 0, 2, 2, Bpp32, image_bytes(2, 2, Bpp32), 1'b1, -1);
      send_file(BmpSignature, 54, 0, 3, Bpp24, 8, 1'b1, -1);
      send_file(BmpSignature, 30, 3, 0, Bpp32, 8, 1'b1, -1);
      send_file(BmpSignature, 30, 3, 2, Bpp24, image_bytes(3, 2, Bpp24), 1'b1, -1);
      send_file(BmpSignature, 30, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Bpp32, 24, 1'b1, -1);
      // trailing bytes after the last row
      send_file(BmpSignature, 30, 1, 1, Bpp32, 12, 1'b1, -1);

      step = 0;
      while (items_sent < Items) begin
         settle();
         burst_mode = ($urandom_range(0, 3) == 0);
         apply_setting((step < 6) ? step : $urandom_range(0, 5));
         if (step == 0) begin
            // stall the result side long enough to back up the input
            hold_request = 1'b1;
            send_file(BmpSignature, 54, 8, 6, Bpp24, image_bytes(8, 6, Bpp24), 1'b1, -1);
         end else if (step == 1) begin
            send_file(BmpSignature, 54, 4, 4, Bpp32, image_bytes(4, 4, Bpp32), 1'b1, 74);
         end
         repeat ($urandom_range(2, 4)) send_random_file();
         step++;
      end

      settle();
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bmprgb_pkg.sv
rtl/bmprgb_front.sv
rtl/bmprgb_queue.sv
rtl/bmprgb_back.sv
rtl/bmp_stream_to_rgb565_pixels.sv
dv/bmp_pixel_checker.sv
dv/tb_bmp_stream_to_rgb565_pixels.sv
